### src/mbrot_pkg.sv
// ---------------------------------------------------------------------------
// mbrot_pkg
// Shared types and constants for the escape-time unit: register indexes,
// field widths and the input and result word layouts.
// ---------------------------------------------------------------------------
`default_nettype none

package mbrot_pkg;

    // Field widths
    localparam int COORD_W  = 31;   // Q3.28 corner coordinates
    localparam int CFG_FRAC = 28;   // fraction bits of the coordinates
    localparam int LIMIT_W  = 16;   // iteration_limit
    localparam int LOG2_W   = 4;    // grid_size_log2
    localparam int INDEX_W  = 12;   // row, col
    localparam int ITER_BITS = 16;  // iterations field of the result word
    localparam int COUNT_W  = 25;   // inside_total

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // Defaults of the top-level parameters
    localparam int MAX_GRID_LOG2_DEF = 12;
    localparam int FRAC_BITS_DEF     = 28;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REAL_MIN   = 3'd0,
        REG_REAL_MAX   = 3'd1,
        REG_IMAG_MIN   = 3'd2,
        REG_IMAG_MAX   = 3'd3,
        REG_ITER_LIMIT = 3'd4,
        REG_GRID_LOG2  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
        logic               clear_count;
    } in_word_t;

    typedef struct packed {
        logic [ITER_BITS-1:0] iterations;
        logic                 inside_res;
        logic [COUNT_W-1:0]   inside_total;
    } out_word_t;

endpackage

`default_nettype wire

### src/mandelbrot_escape_time_unit.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time engine for one pixel: maps (row, col) to c, iterates
// z = z^2 + c and keeps a running count of pixels that stay inside.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+-----------------------------
//  s_       | in        | s_valid / s_ready   | row, col, clear_count
//  m_       | out       | m_valid / m_ready   | iterations, inside_res,
//           |           |                     | inside_total
//  cfg_     | in        | cfg_wr_en (no wait) | cfg_index, cfg_wdata
//
//  A pixel holds the unit from its accept edge to the next accept: the
//  idle state takes the word, ST_MAP forms the mapping products, ST_CONV
//  shifts/saturates c, each iteration goes through the shared square/cross
//  multiplier bank in ST_MUL and then adds and runs the escape test in
//  ST_ADD, a last ST_MUL pass (plus its escape test in ST_ADD on escape)
//  ends the loop and ST_DONE loads the result.
//  s_ready is high only while idle; one pixel is in flight at a time.
//  The result sits in an output register, so a stalled m_ready only holds
//  the finished word and the sequencer waits in its done state.
//  aresetn (synchronous, active low) loads the register defaults and
//  clears the inside counter and all handshake state.
// ---------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_unit #(
    parameter int MAX_GRID_LOG2 = mbrot_pkg::MAX_GRID_LOG2_DEF,
    parameter int FRAC_BITS     = mbrot_pkg::FRAC_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 cfg_wr_en,
    input  wire  [mbrot_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  wire  [mbrot_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  mbrot_pkg::in_word_t                 s_data,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output mbrot_pkg::out_word_t                m_data
);

    // Widths
    localparam int CW   = mbrot_pkg::COORD_W;
    localparam int XW   = FRAC_BITS + 4;            // |x|,|y| < 8
    localparam int PW   = 2 * XW;                   // raw products
    localparam int SW   = XW + 4;                   // floored squares, < 64
    localparam int LGW  = $clog2(MAX_GRID_LOG2 + 1);
    localparam int MAPW = CW + MAX_GRID_LOG2 + 3;   // mapping sum
    localparam int UP   = (FRAC_BITS >= mbrot_pkg::CFG_FRAC) ?
                          FRAC_BITS - mbrot_pkg::CFG_FRAC : 0;
    localparam int DN   = (FRAC_BITS <  mbrot_pkg::CFG_FRAC) ?
                          mbrot_pkg::CFG_FRAC - FRAC_BITS : 0;
    localparam int TW   = CW + UP;                  // coordinate in new format
    localparam int LW   = mbrot_pkg::LIMIT_W;
    localparam int NW   = mbrot_pkg::COUNT_W;

    localparam logic signed [SW-1:0] FOUR = SW'(4) <<< FRAC_BITS;
    localparam logic [NW-1:0]        COUNT_MAX = {NW{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_CONV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0]              real_min_reg, real_max_reg;
    logic signed [CW-1:0]              imag_min_reg, imag_max_reg;
    logic [LW-1:0]                     limit_reg;
    logic [mbrot_pkg::LOG2_W-1:0]      grid_log2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_min_reg  <= -CW'(32'sd536870912);
            real_max_reg  <= CW'(32'sd268435456);
            imag_min_reg  <= -CW'(32'sd268435456);
            imag_max_reg  <= CW'(32'sd268435456);
            limit_reg     <= LW'(256);
            grid_log2_reg <= mbrot_pkg::LOG2_W'(8);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbrot_pkg::REG_REAL_MIN:   real_min_reg  <= cfg_wdata[CW-1:0];
                mbrot_pkg::REG_REAL_MAX:   real_max_reg  <= cfg_wdata[CW-1:0];
                mbrot_pkg::REG_IMAG_MIN:   imag_min_reg  <= cfg_wdata[CW-1:0];
                mbrot_pkg::REG_IMAG_MAX:   imag_max_reg  <= cfg_wdata[CW-1:0];
                mbrot_pkg::REG_ITER_LIMIT: limit_reg     <= cfg_wdata[LW-1:0];
                mbrot_pkg::REG_GRID_LOG2:
                    grid_log2_reg <= cfg_wdata[mbrot_pkg::LOG2_W-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    state_t                      state_reg;
    logic                        m_valid_reg;
    mbrot_pkg::out_word_t        m_data_reg;
    logic [NW-1:0]               count_reg;

    logic [mbrot_pkg::INDEX_W-1:0] row_reg, col_reg;
    logic                        clear_reg;
    logic signed [MAPW-1:0]      map_r_reg, map_i_reg;
    logic signed [XW-1:0]        cr_reg, ci_reg, x_reg, y_reg;
    logic signed [PW-1:0]        pxx_reg, pyy_reg, pxy_reg;
    logic [LW-1:0]               iter_reg;

    // ---------------- combinational helpers ----------------
    logic [LGW-1:0]              lg;
    logic signed [CW:0]          diff_r, diff_i;
    logic signed [MAPW-1:0]      sum_r, sum_i, shr_r, shr_i;
    logic signed [CW-1:0]        sat_r, sat_i;
    logic signed [TW-1:0]        cvt_r, cvt_i;
    logic signed [SW-1:0]        sx, sy, sum_sq, x_wide;
    logic signed [XW-1:0]        x_next, y_next;
    logic                        in_set;
    logic [NW-1:0]               count_base, count_next;

    // Grid log2 clamped to [1, MAX_GRID_LOG2]
    always_comb begin
        if (grid_log2_reg == '0) begin
            lg = LGW'(1);
        end else if (int'(grid_log2_reg) > MAX_GRID_LOG2) begin
            lg = LGW'(MAX_GRID_LOG2);
        end else begin
            lg = LGW'(grid_log2_reg);
        end
    end

    // c = (min*S + (max-min)*k) >> lg, floor; products come from map_*_reg
    always_comb begin
        diff_r = {real_max_reg[CW-1], real_max_reg} - {real_min_reg[CW-1], real_min_reg};
        diff_i = {imag_max_reg[CW-1], imag_max_reg} - {imag_min_reg[CW-1], imag_min_reg};
        sum_r  = map_r_reg + ({{(MAPW-CW){real_min_reg[CW-1]}}, real_min_reg} <<< lg);
        sum_i  = map_i_reg + ({{(MAPW-CW){imag_min_reg[CW-1]}}, imag_min_reg} <<< lg);
        shr_r  = sum_r >>> lg;
        shr_i  = sum_i >>> lg;
        // saturate to the 31-bit coordinate range
        if (shr_r[MAPW-1:CW-1] != {(MAPW-CW+1){shr_r[MAPW-1]}}) begin
            sat_r = shr_r[MAPW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat_r = shr_r[CW-1:0];
        end
        if (shr_i[MAPW-1:CW-1] != {(MAPW-CW+1){shr_i[MAPW-1]}}) begin
            sat_i = shr_i[MAPW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat_i = shr_i[CW-1:0];
        end
        // move to FRAC_BITS fraction bits (floor when narrowing)
        cvt_r = (TW'(sat_r) <<< UP) >>> DN;
        cvt_i = (TW'(sat_i) <<< UP) >>> DN;
    end

    // Iteration update from the registered products
    always_comb begin
        sx     = SW'(pxx_reg >>> FRAC_BITS);
        sy     = SW'(pyy_reg >>> FRAC_BITS);
        sum_sq = sx + sy;
        x_wide = sx - sy + {{(SW-XW){cr_reg[XW-1]}}, cr_reg};
        x_next = x_wide[XW-1:0];
        y_next = XW'(pxy_reg >>> (FRAC_BITS - 1)) + ci_reg;
    end

    // Inside test and saturating counter
    always_comb begin
        in_set     = iter_reg > (limit_reg >> 1);
        count_base = clear_reg ? '0 : count_reg;
        count_next = (in_set && count_base != COUNT_MAX) ? count_base + NW'(1)
                                                         : count_base;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            // in the done state the result load below owns m_valid_reg
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        row_reg   <= s_data.row;
                        col_reg   <= s_data.col;
                        clear_reg <= s_data.clear_count;
                        state_reg <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    map_r_reg <= MAPW'(diff_r * $signed({1'b0, col_reg}));
                    map_i_reg <= MAPW'(diff_i * $signed({1'b0, row_reg}));
                    state_reg <= ST_CONV;
                end
                ST_CONV: begin
                    cr_reg    <= XW'(cvt_r);
                    ci_reg    <= XW'(cvt_i);
                    x_reg     <= '0;
                    y_reg     <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    pxx_reg <= PW'(x_reg * x_reg);
                    pyy_reg <= PW'(y_reg * y_reg);
                    pxy_reg <= PW'(x_reg * y_reg);
                    state_reg <= (iter_reg < limit_reg) ? ST_ADD : ST_DONE;
                end
                ST_ADD: begin
                    if (sum_sq >= FOUR) begin
                        state_reg <= ST_DONE;
                    end else begin
                        x_reg     <= x_next;
                        y_reg     <= y_next;
                        iter_reg  <= iter_reg + LW'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.iterations      <= mbrot_pkg::ITER_BITS'(iter_reg);
                        m_data_reg.inside_res      <= in_set;
                        m_data_reg.inside_total    <= count_next;
                        count_reg                  <= count_next;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
